>>> rtl/circular_fifo_queue_top_assert.svh
// Assertion macros shared by the queue RTL; empty bodies in synthesis.
`ifndef CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define CFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cfq_pkg.sv
// Shared types, codes and defaults for the circular FIFO queue.
package cfq_pkg;

    localparam int MAX_ENTRIES_DEF = 63;
    localparam int WORD_BITS_DEF   = 32;
    localparam int CAP_BITS        = 6;
    localparam int KIND_BITS       = 2;
    localparam int STATUS_BITS     = 2;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd63;

    // Command codes carried in the kind field
    typedef enum logic [KIND_BITS-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec;   // item accepted: update pointers, write or read the ring
        logic load;   // move the finished result into the output register
    } ctrl_cmd_t;

endpackage

>>> rtl/cfq_if.sv
// Valid/ready channel interfaces for commands and results.
interface cfq_cmd_if #(
    parameter int WORD_BITS = cfq_pkg::WORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [cfq_pkg::KIND_BITS-1:0]  kind;
    logic [WORD_BITS-1:0]           data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface cfq_rsp_if #(
    parameter int WORD_BITS  = cfq_pkg::WORD_BITS_DEF,
    parameter int COUNT_BITS = $clog2(cfq_pkg::MAX_ENTRIES_DEF + 1)
);
    logic                             valid;
    logic                             ready;
    logic [cfq_pkg::STATUS_BITS-1:0]  status;
    logic [WORD_BITS-1:0]             data_out;
    logic [COUNT_BITS-1:0]            count;
    logic                             is_empty;
    logic                             is_full;

    modport source (output valid, output status, output data_out, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input data_out, input count,
                    input is_empty, input is_full, output ready);
endinterface

>>> rtl/cfq_ctrl.sv
// Controller: accepts items, sequences the ring access and the result register.
`include "circular_fifo_queue_top_assert.svh"

module cfq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output cfq_pkg::ctrl_cmd_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Handshake decode
    always_comb
    begin
        cmd_ready  = (state_reg == ST_IDLE);
        ctrl.exec  = cmd_valid && cmd_ready;
        ctrl.load  = (state_reg == ST_EXEC) && (!out_valid_reg || rsp_ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.exec)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (ctrl.load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `CFQ_ASSERT_NEXT(a_exec_enters_exec, clk, rst_n, ctrl.exec, state_reg == ST_EXEC)
    `CFQ_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, ctrl.load, out_valid_reg)
    `CFQ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_reg && !rsp_ready, !ctrl.load)

endmodule

>>> rtl/cfq_dpath.sv
// Datapath: capacity register, ring pointers, slot memory and result registers.
`include "circular_fifo_queue_top_assert.svh"

module cfq_dpath #(
    parameter int MAX_ENTRIES = cfq_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_BITS   = cfq_pkg::WORD_BITS_DEF,
    parameter int PTR_BITS    = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cfq_pkg::CAP_BITS-1:0]     cfg_wdata,
    input  cfq_pkg::ctrl_cmd_t               ctrl,
    input  logic [cfq_pkg::KIND_BITS-1:0]    kind,
    input  logic [WORD_BITS-1:0]             data_in,
    output logic [cfq_pkg::STATUS_BITS-1:0]  status,
    output logic [WORD_BITS-1:0]             data_out,
    output logic [PTR_BITS-1:0]              count,
    output logic                             is_empty,
    output logic                             is_full
);

    localparam int RING = MAX_ENTRIES + 1;

    logic [cfq_pkg::CAP_BITS-1:0] capacity_reg;
    logic [PTR_BITS-1:0]          head_reg, head_next;
    logic [PTR_BITS-1:0]          tail_reg, tail_next;
    logic [PTR_BITS-1:0]          cap_eff;
    logic [PTR_BITS-1:0]          tail_adv, head_adv;
    logic                         full_now, empty_now;
    logic                         wr_en, word_sel;
    cfq_pkg::status_t             st_now;

    logic [WORD_BITS-1:0]         mem [RING];
    logic [WORD_BITS-1:0]         rd_data_reg;
    cfq_pkg::status_t             pend_status_reg;
    logic                         pend_sel_reg;
    logic [PTR_BITS-1:0]          count_now;

    cfq_pkg::status_t             status_reg;
    logic [WORD_BITS-1:0]         data_out_reg;
    logic [PTR_BITS-1:0]          count_reg;
    logic                         empty_reg, full_reg;

    // Effective capacity: zero acts as one, clamp to MAX_ENTRIES
    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = PTR_BITS'(1);
        else if (int'(capacity_reg) > MAX_ENTRIES)
            cap_eff = PTR_BITS'(MAX_ENTRIES);
        else
            cap_eff = PTR_BITS'(capacity_reg);
    end

    // Wrapping increments; last slot index equals cap_eff
    assign tail_adv  = (tail_reg == cap_eff) ? '0 : tail_reg + PTR_BITS'(1);
    assign head_adv  = (head_reg == cap_eff) ? '0 : head_reg + PTR_BITS'(1);
    assign full_now  = (tail_adv == head_reg);
    assign empty_now = (head_reg == tail_reg);

    // Command decode
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        st_now    = cfq_pkg::STAT_OK;
        wr_en     = 1'b0;
        word_sel  = 1'b0;
        if (cfg_we)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else if (ctrl.exec)
        begin
            unique case (kind)
                cfq_pkg::CMD_PUSH:
                begin
                    if (full_now)
                        st_now = cfq_pkg::STAT_FULL;
                    else
                    begin
                        wr_en     = 1'b1;
                        tail_next = tail_adv;
                    end
                end
                cfq_pkg::CMD_POP:
                begin
                    if (empty_now)
                        st_now = cfq_pkg::STAT_EMPTY;
                    else
                    begin
                        word_sel  = 1'b1;
                        head_next = head_adv;
                    end
                end
                cfq_pkg::CMD_PEEK:
                begin
                    if (empty_now)
                        st_now = cfq_pkg::STAT_EMPTY;
                    else
                        word_sel = 1'b1;
                end
                cfq_pkg::CMD_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    // Capacity register and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cfq_pkg::CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Slot memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= data_in;
        if (ctrl.exec)
            rd_data_reg <= mem[head_reg];
    end

    // Pending result of the item in flight
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            pend_status_reg <= st_now;
            pend_sel_reg    <= word_sel;
        end
    end

    // Stored count from the updated pointers, modulo cap_eff + 1
    assign count_now = (tail_reg >= head_reg) ? tail_reg - head_reg
                     : PTR_BITS'(tail_reg - head_reg + cap_eff + PTR_BITS'(1));

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            status_reg   <= pend_status_reg;
            data_out_reg <= pend_sel_reg ? rd_data_reg : '0;
            count_reg    <= count_now;
            empty_reg    <= (count_now == '0);
            full_reg     <= (count_now == cap_eff);
        end
    end

    assign status   = status_reg;
    assign data_out = data_out_reg;
    assign count    = count_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

    `CFQ_ASSERT_IMPL(a_head_in_ring, clk, rst_n, 1'b1, head_reg <= cap_eff && tail_reg <= cap_eff)
    `CFQ_ASSERT_NEXT(a_full_push_holds, clk, rst_n, ctrl.exec && !cfg_we && kind == cfq_pkg::CMD_PUSH && full_now, tail_reg == $past(tail_reg) && head_reg == $past(head_reg))
    `CFQ_ASSERT_IMPL(a_count_in_range, clk, rst_n, ctrl.load, count_now <= cap_eff)

endmodule

>>> rtl/circular_fifo_queue_top.sv
// The pointers move and the head slot is read at the accept edge; the result register loads
//   in ST_EXEC, held there while an untaken result waits.
// The controller accepts an item, then loads its result in ST_EXEC before it accepts again,
//   so it takes no new item until the last one is loaded. A waiting result does not block the
//   next accept; it only holds the following load.
// Reset (async, active low) empties the queue and sets capacity to 63; slots are not cleared.
module circular_fifo_queue_top #(
    parameter int MAX_ENTRIES = cfq_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_BITS   = cfq_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cfq_pkg::CAP_BITS-1:0] cfg_wdata,
    cfq_cmd_if.sink                      cmd_ch,
    cfq_rsp_if.source                    rsp_ch
);

    localparam int PTR_BITS = $clog2(MAX_ENTRIES + 1);

    cfq_pkg::ctrl_cmd_t ctrl;
    logic               cmd_ready;
    logic               rsp_valid;

    // Controller
    cfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_ch.valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ch.ready),
        .ctrl      (ctrl)
    );

    // Datapath
    cfq_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_BITS   (WORD_BITS),
        .PTR_BITS    (PTR_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .kind      (cmd_ch.kind),
        .data_in   (cmd_ch.data_in),
        .status    (rsp_ch.status),
        .data_out  (rsp_ch.data_out),
        .count     (rsp_ch.count),
        .is_empty  (rsp_ch.is_empty),
        .is_full   (rsp_ch.is_full)
    );

    assign cmd_ch.ready = cmd_ready;
    assign rsp_ch.valid = rsp_valid;

endmodule
